// ===== hw/rtl/mfmt_pkg.sv =====
// Shared types, widths and constants of the multi-turn motor feedback tracker.
`default_nettype none

package mfmt_pkg;

    // Default number of motors in each of the two groups.
    localparam int MOTORS_PER_GROUP_DEF = 4;

    localparam int ENC_W    = 16;
    localparam int TURN_W   = 16;
    localparam int ANGLE_W  = 40;
    localparam int SCALE_W  = 32;
    localparam int COUNTS_W = 30;
    localparam int PROD_W   = 63;
    localparam int ENTRY_W  = ENC_W + TURN_W;

    // Encoder jump beyond which a wrap is assumed.
    localparam logic signed [ENC_W:0] JUMP_LIMIT_POS = 17'sd4096;
    localparam logic signed [ENC_W:0] JUMP_LIMIT_NEG = -17'sd4096;

    // Rounding constant for the Q.32 to Q16.16 step (one half of the dropped part).
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 63'sd32768;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 40'sh7FFFFFFFFF;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 40'sh8000000000;

    // Register file.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0]         REG_ANGLE_SCALE = 1'b0;
    localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST = 32'd9933878;

    typedef struct packed {
        logic        motor_group;
        logic [1:0]  motor_index;
        logic [63:0] frame_payload;
    } frame_t;

    typedef struct packed {
        logic        [ENC_W-1:0]   encoder_count;
        logic signed [15:0]        rotor_speed;
        logic signed [15:0]        drive_current;
        logic        [7:0]         temperature;
        logic signed [TURN_W-1:0]  turn_count;
        logic signed [ANGLE_W-1:0] shaft_angle;
        logic signed [ANGLE_W-1:0] angle_change;
    } result_t;

    // Unpacked frame plus updated turn count, handed from the turn stage to the angle stages.
    typedef struct packed {
        logic                       valid;
        logic        [ENC_W-1:0]    enc;
        logic signed [15:0]         spd;
        logic signed [15:0]         cur;
        logic        [7:0]          tmp;
        logic signed [TURN_W-1:0]   turns;
        logic signed [COUNTS_W-1:0] counts;
    } track_t;

endpackage

`default_nettype wire

// ===== hw/rtl/motor_feedback_multiturn_tracker_unit.sv =====
// Top level of the multi-turn motor feedback tracker.
`default_nettype none

// The tracker takes one 8-byte feedback frame per transaction on the frame channel,
// tagged with a motor group and an index within that group, and returns exactly one
// result transaction per frame, in order. Bytes 0..6 are unpacked big-endian into encoder
// count, speed, current and temperature. For each motor it keeps the last encoder count,
// a signed turn counter and the last total angle; an encoder jump above 4096 counts
// decrements the turn counter and one below -4096 increments it. The total angle is
// (turns*8192 + encoder) times angle_scale (unsigned Q0.32 degrees per count), rounded
// half up to signed Q16.16 and clamped to 40 bits; angle_change is the previous angle
// minus the new one, also clamped. Motor indices at or above MOTORS_PER_GROUP wrap
// modulo the group size. The per-motor state lives in two small RAMs with a registered
// read: encoder and turn count are read when a frame is accepted and written back from
// the turn stage, the last angle is read at acceptance and written back from the r4
// stage, and back-to-back frames for the same motor are served by forwarding, so there
// is no interlock. A new frame is accepted every clock cycle while the skid entry is
// empty; a result passes through the r1 to r4 stage registers and the output register.
// The output carries a one-entry skid buffer: when the output register is held, the
// next result parks in the skid entry and the input stalls from the following cycle
// until the output register drains. All state reads as zero after reset through
// per-entry valid flags, so no clearing pass is needed. angle_scale sits at byte
// address 0 of the configuration port and resets to 9933878 (about 360/(19*8192));
// it should be written only while no transaction is in flight.
module motor_feedback_multiturn_tracker_unit
    import mfmt_pkg::*;
#(
    parameter int MOTORS_PER_GROUP = MOTORS_PER_GROUP_DEF,
    localparam int SLOTS  = 2 * MOTORS_PER_GROUP,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  frame_valid,
    output logic                       frame_stall,
    input  wire frame_t                frame,

    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [SCALE_W-1:0] angle_scale;
    logic [SLOT_W-1:0]  slot_in;
    logic [SLOT_W-1:0]  slot_r1;
    track_t             trk;
    logic               adv;

    // The whole pipeline moves together; it only halts once the skid entry is occupied.
    assign frame_stall = !adv;

    mfmt_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .angle_scale (angle_scale)
    );

    mfmt_turn #(
        .MOTORS_PER_GROUP (MOTORS_PER_GROUP)
    ) u_turn (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .frame_valid (frame_valid),
        .frame       (frame),
        .slot_in     (slot_in),
        .slot_r1     (slot_r1),
        .trk         (trk)
    );

    mfmt_angle #(
        .MOTORS_PER_GROUP (MOTORS_PER_GROUP)
    ) u_angle (
        .clk          (clk),
        .rst_n        (rst_n),
        .angle_scale  (angle_scale),
        .trk          (trk),
        .slot_in      (slot_in),
        .slot_r1      (slot_r1),
        .adv          (adv),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mfmt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module mfmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-first: a read at the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mfmt_regs.sv =====
// APB-style configuration register file holding the angle scale.
`default_nettype none

module mfmt_regs
    import mfmt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [SCALE_W-1:0]    angle_scale
);

    logic [SCALE_W-1:0] scale_reg;
    logic               wr_en;

    assign pready      = 1'b1;
    assign wr_en       = psel && penable && pwrite;
    assign angle_scale = scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= ANGLE_SCALE_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_ANGLE_SCALE: scale_reg <= pwdata;
                default:         scale_reg <= scale_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ANGLE_SCALE: prdata = scale_reg;
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mfmt_turn.sv =====
// Turn stage: slot decode, encoder/turn memory read-modify-write and unwrap.
`default_nettype none

module mfmt_turn
    import mfmt_pkg::*;
#(
    parameter int MOTORS_PER_GROUP = MOTORS_PER_GROUP_DEF,
    localparam int SLOTS  = 2 * MOTORS_PER_GROUP,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              frame_valid,
    input  wire frame_t            frame,
    output logic      [SLOT_W-1:0] slot_in,
    output logic      [SLOT_W-1:0] slot_r1,
    output track_t                 trk
);

    logic [4:0]         idx_v;
    logic [5:0]         slot_wide;

    logic               r1_valid_reg;
    frame_t             r1_frame_reg;
    logic [SLOT_W-1:0]  r1_slot_reg;
    logic               r1_seen_reg;
    logic               r1_fwd_reg;
    logic [ENTRY_W-1:0] r1_fwd_data_reg;
    logic [SLOTS-1:0]   seen_reg;
    logic [SLOTS-1:0]   seen_next;

    logic [ENTRY_W-1:0]       rd_data;
    logic [ENTRY_W-1:0]       last_entry;
    logic [ENC_W-1:0]         enc;
    logic [ENC_W-1:0]         last_enc;
    logic [TURN_W-1:0]        last_turn;
    logic [TURN_W-1:0]        turn_new;
    logic signed [ENC_W:0]    jump;
    logic [COUNTS_W-1:0]      counts;
    logic                     wr_en;

    // Motor index folded into the group size, then placed after the first group for group one.
    always_comb
    begin
        idx_v = {3'd0, frame.motor_index};
        for (int k = 0; k < 3; k++)
        begin
            if (idx_v >= 5'(MOTORS_PER_GROUP))
            begin
                idx_v = idx_v - 5'(MOTORS_PER_GROUP);
            end
        end
        slot_wide = (frame.motor_group ? 6'(MOTORS_PER_GROUP) : 6'd0) + {1'b0, idx_v};
    end

    assign slot_in = slot_wide[SLOT_W-1:0];
    assign slot_r1 = r1_slot_reg;
    assign wr_en   = adv && r1_valid_reg;

    mfmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_turn_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (r1_slot_reg),
        .wr_data ({enc, turn_new}),
        .rd_en   (adv),
        .rd_addr (slot_in),
        .rd_data (rd_data)
    );

    always_comb
    begin
        seen_next = seen_reg;
        if (wr_en)
        begin
            seen_next[r1_slot_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r1_seen_reg  <= 1'b0;
            r1_fwd_reg   <= 1'b0;
            seen_reg     <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (adv)
            begin
                r1_valid_reg <= frame_valid;
                r1_seen_reg  <= seen_reg[slot_in];
                r1_fwd_reg   <= r1_valid_reg && (r1_slot_reg == slot_in);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_frame_reg    <= frame;
            r1_slot_reg     <= slot_in;
            r1_fwd_data_reg <= {enc, turn_new};
        end
    end

    // A write landing at the same edge as the read is picked up from the forward register.
    always_comb
    begin
        if (r1_fwd_reg)
        begin
            last_entry = r1_fwd_data_reg;
        end
        else if (r1_seen_reg)
        begin
            last_entry = rd_data;
        end
        else
        begin
            last_entry = '0;
        end
        last_enc  = last_entry[ENTRY_W-1:TURN_W];
        last_turn = last_entry[TURN_W-1:0];
        enc       = r1_frame_reg.frame_payload[63:48];
        jump      = $signed({1'b0, enc}) - $signed({1'b0, last_enc});
        if (jump > JUMP_LIMIT_POS)
        begin
            turn_new = last_turn - 16'd1;
        end
        else if (jump < JUMP_LIMIT_NEG)
        begin
            turn_new = last_turn + 16'd1;
        end
        else
        begin
            turn_new = last_turn;
        end
        counts = {turn_new[TURN_W-1], turn_new, 13'd0} + {14'd0, enc};
    end

    always_comb
    begin
        trk.valid  = r1_valid_reg;
        trk.enc    = enc;
        trk.spd    = r1_frame_reg.frame_payload[47:32];
        trk.cur    = r1_frame_reg.frame_payload[31:16];
        trk.tmp    = r1_frame_reg.frame_payload[15:8];
        trk.turns  = turn_new;
        trk.counts = counts;
    end

    a_seen_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && r1_valid_reg) |=> seen_reg[$past(r1_slot_reg)])
        else $error("turn memory entry written but not marked as seen");

endmodule

`default_nettype wire

// ===== hw/rtl/mfmt_angle.sv =====
// Angle stages: scale multiply, rounding, last-angle memory, change and output buffer.
`default_nettype none

module mfmt_angle
    import mfmt_pkg::*;
#(
    parameter int MOTORS_PER_GROUP = MOTORS_PER_GROUP_DEF,
    localparam int SLOTS  = 2 * MOTORS_PER_GROUP,
    localparam int SLOT_W = $clog2(SLOTS)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [SCALE_W-1:0] angle_scale,
    input  wire track_t             trk,
    input  wire logic [SLOT_W-1:0]  slot_in,
    input  wire logic [SLOT_W-1:0]  slot_r1,
    output logic                    adv,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output result_t                 result
);

    // Forward state that sits beside the turn stage.
    logic               p1_seen_reg;
    logic               p1_fwd_reg;
    logic [ANGLE_W-1:0] p1_fwd_data_reg;
    logic [SLOTS-1:0]   seen_reg;
    logic [SLOTS-1:0]   seen_next;
    logic [ANGLE_W-1:0] rd_data;
    logic [ANGLE_W-1:0] prev_r1;

    logic                      r2_valid_reg;
    track_t                    r2_trk_reg;
    logic [SLOT_W-1:0]         r2_slot_reg;
    logic [ANGLE_W-1:0]        r2_prev_reg;

    logic                      r3_valid_reg;
    track_t                    r3_trk_reg;
    logic [SLOT_W-1:0]         r3_slot_reg;
    logic [ANGLE_W-1:0]        r3_prev_reg;
    logic signed [PROD_W-1:0]  r3_prod_reg;

    logic                      r4_valid_reg;
    track_t                    r4_trk_reg;
    logic [SLOT_W-1:0]         r4_slot_reg;
    logic [ANGLE_W-1:0]        r4_prev_reg;
    logic signed [ANGLE_W-1:0] r4_ang_reg;

    logic                      wr_en;
    logic signed [32:0]        scale_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  rnd;
    logic [PROD_W-17:0]        shifted;
    logic signed [ANGLE_W-1:0] ang;
    logic signed [ANGLE_W:0]   diff;
    logic signed [ANGLE_W-1:0] chg;
    result_t                   res_new;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;
    logic    arrive;
    logic    out_fire;
    logic    out_valid_next;
    logic    skid_valid_next;
    logic    load_out_new;
    logic    load_out_skid;
    logic    load_skid;

    assign adv   = !skid_valid_reg;
    assign wr_en = adv && r4_valid_reg;

    mfmt_ram #(
        .WIDTH (ANGLE_W),
        .DEPTH (SLOTS)
    ) u_angle_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (r4_slot_reg),
        .wr_data (r4_ang_reg),
        .rd_en   (adv),
        .rd_addr (slot_in),
        .rd_data (rd_data)
    );

    always_comb
    begin
        seen_next = seen_reg;
        if (wr_en)
        begin
            seen_next[r4_slot_reg] = 1'b1;
        end
    end

    always_comb
    begin
        if (p1_fwd_reg)
        begin
            prev_r1 = p1_fwd_data_reg;
        end
        else if (p1_seen_reg)
        begin
            prev_r1 = rd_data;
        end
        else
        begin
            prev_r1 = '0;
        end
    end

    // Multiply, then round half up to Q16.16 and clamp to 40 bits.
    always_comb
    begin
        scale_s = $signed({1'b0, angle_scale});
        prod    = r2_trk_reg.counts * scale_s;
        rnd     = r3_prod_reg + ROUND_HALF;
        shifted = rnd[PROD_W-1:16];
        if ((&shifted[PROD_W-17:ANGLE_W-1]) || !(|shifted[PROD_W-17:ANGLE_W-1]))
        begin
            ang = $signed(shifted[ANGLE_W-1:0]);
        end
        else if (shifted[PROD_W-17])
        begin
            ang = ANGLE_MIN;
        end
        else
        begin
            ang = ANGLE_MAX;
        end
    end

    always_comb
    begin
        diff = $signed({r4_prev_reg[ANGLE_W-1], r4_prev_reg})
             - $signed({r4_ang_reg[ANGLE_W-1], r4_ang_reg});
        if (diff[ANGLE_W] == diff[ANGLE_W-1])
        begin
            chg = diff[ANGLE_W-1:0];
        end
        else if (diff[ANGLE_W])
        begin
            chg = ANGLE_MIN;
        end
        else
        begin
            chg = ANGLE_MAX;
        end
        res_new.encoder_count = r4_trk_reg.enc;
        res_new.rotor_speed   = r4_trk_reg.spd;
        res_new.drive_current = r4_trk_reg.cur;
        res_new.temperature   = r4_trk_reg.tmp;
        res_new.turn_count    = r4_trk_reg.turns;
        res_new.shaft_angle   = r4_ang_reg;
        res_new.angle_change  = chg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_seen_reg  <= 1'b0;
            p1_fwd_reg   <= 1'b0;
            seen_reg     <= '0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            r4_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (adv)
            begin
                p1_seen_reg  <= seen_reg[slot_in];
                p1_fwd_reg   <= r4_valid_reg && (r4_slot_reg == slot_in);
                r2_valid_reg <= trk.valid;
                r3_valid_reg <= r2_valid_reg;
                r4_valid_reg <= r3_valid_reg;
            end
        end
    end

    // Every stage snoops the angle being written so it always holds the newest one.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_fwd_data_reg <= r4_ang_reg;

            r2_trk_reg  <= trk;
            r2_slot_reg <= slot_r1;
            r2_prev_reg <= (r4_valid_reg && (r4_slot_reg == slot_r1)) ? r4_ang_reg : prev_r1;

            r3_trk_reg  <= r2_trk_reg;
            r3_slot_reg <= r2_slot_reg;
            r3_prod_reg <= prod;
            r3_prev_reg <= (r4_valid_reg && (r4_slot_reg == r2_slot_reg)) ? r4_ang_reg
                                                                          : r2_prev_reg;

            r4_trk_reg  <= r3_trk_reg;
            r4_slot_reg <= r3_slot_reg;
            r4_ang_reg  <= ang;
            r4_prev_reg <= (r4_valid_reg && (r4_slot_reg == r3_slot_reg)) ? r4_ang_reg
                                                                          : r3_prev_reg;
        end
    end

    // Output register plus one skid entry.
    always_comb
    begin
        arrive          = adv && r4_valid_reg;
        out_fire        = out_valid_reg && !result_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_new    = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                load_out_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (arrive)
        begin
            if (!out_valid_reg || out_fire)
            begin
                load_out_new   = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_new)
        begin
            out_reg <= res_new;
        end
        else if (load_out_skid)
        begin
            out_reg <= skid_reg;
        end
        if (load_skid)
        begin
            skid_reg <= res_new;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in the output register");

    a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && r4_valid_reg) |=> result_valid)
        else $error("finished transaction left the pipeline without reaching the output");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(r2_valid_reg) && $stable(r3_valid_reg) && $stable(r4_valid_reg)))
        else $error("pipeline moved while the output buffer was full");

endmodule

`default_nettype wire

// ===== tb/sv/motor_feedback_multiturn_tracker_unit_tb.sv =====
// Self-checking testbench for the multi-turn motor feedback tracker.
module motor_feedback_multiturn_tracker_unit_tb;
    import mfmt_pkg::*;

    // The block is built with its default group size; the predictor keeps one
    // entry per motor across both groups.
    localparam int MOTORS = MOTORS_PER_GROUP_DEF;
    localparam int SLOTS = 2 * MOTORS;

    // Register map as seen on the configuration port. Byte address four is
    // register index one, which the block does not implement.
    localparam logic [APB_ADDR_W-1:0] SCALE_ADDR = {REG_ANGLE_SCALE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = 3'd4;

    // Limits of the signed 40-bit Q16.16 angle.
    localparam longint ANGLE_HI = 64'sd549755813887;
    localparam longint ANGLE_LO = -64'sd549755813888;

    // Motor used for the multi-lap winding sequence.
    localparam logic WIND_GROUP = 1'b1;
    localparam logic [1:0] WIND_INDEX = 2'd3;

    // The settle time at the end covers a result's way through the block with
    // room to spare. The cycle limit is several times the slowest legal run,
    // which is dominated by the idle mixes and the long receiver hold-off.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 20000;

    // Every input of the block starts at a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic frame_valid = 1'b0;
    logic frame_stall;
    frame_t frame = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // Predictor copy of the block's configuration and per-motor state.
    logic [SCALE_W-1:0] scale_q = ANGLE_SCALE_RST;
    logic [ENC_W-1:0] enc_state [SLOTS] = '{default: '0};
    logic signed [TURN_W-1:0] turn_state [SLOTS] = '{default: '0};
    longint angle_state [SLOTS] = '{default: 0};

    // Feedback results predicted at frame acceptance, oldest first.
    result_t unwrapped_feedback [$];

    // Percentages of cycles in which the sender and the receiver hold back, and
    // the length of a forced receiver hold-off still to run.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_hold_cycles = 0;

    int frames_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int cycle_count = 0;

    motor_feedback_multiturn_tracker_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // The run is stopped here if it ever hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Every mismatch goes through here: one line each, and all of them counted.
    task automatic log_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH (cycle %0d): %s", cycle_count, msg);
    endtask

    function automatic longint clamp_angle(input longint v);
        if (v > ANGLE_HI)
            return ANGLE_HI;
        if (v < ANGLE_LO)
            return ANGLE_LO;
        return v;
    endfunction

    // Predicts the result of one frame and advances the per-motor state. The
    // jump test, the turn update, the Q.32 product rounded half up to Q16.16
    // and both clamps follow the tracker's definition exactly.
    function automatic result_t unwrap_feedback(input frame_t f);
        int slot;
        int jump;
        int enc_new;
        int enc_old;
        longint turns;
        longint counts;
        longint scale;
        longint angle;
        longint change;
        logic [ENC_W-1:0] enc;
        result_t r;
        slot = f.motor_group * MOTORS + (f.motor_index % MOTORS);
        enc = f.frame_payload[63:48];
        enc_new = int'(enc);
        enc_old = int'(enc_state[slot]);
        jump = enc_new - enc_old;
        if (jump > 4096)
            turn_state[slot] = turn_state[slot] - 16'sd1;
        else if (jump < -4096)
            turn_state[slot] = turn_state[slot] + 16'sd1;
        enc_state[slot] = enc;
        turns = longint'(turn_state[slot]);
        counts = turns * 8192 + longint'(enc_new);
        scale = longint'(scale_q);
        angle = clamp_angle((counts * scale + 64'sd32768) >>> 16);
        change = clamp_angle(angle_state[slot] - angle);
        r.encoder_count = enc;
        r.rotor_speed = f.frame_payload[47:32];
        r.drive_current = f.frame_payload[31:16];
        r.temperature = f.frame_payload[15:8];
        r.turn_count = turn_state[slot];
        r.shaft_angle = angle[ANGLE_W-1:0];
        r.angle_change = change[ANGLE_W-1:0];
        angle_state[slot] = angle;
        return r;
    endfunction

    task automatic check_result(input result_t got, input result_t want);
        if (got.encoder_count !== want.encoder_count)
            log_mismatch($sformatf("encoder_count got %0d expected %0d",
                got.encoder_count, want.encoder_count));
        if (got.rotor_speed !== want.rotor_speed)
            log_mismatch($sformatf("rotor_speed got %0d expected %0d",
                got.rotor_speed, want.rotor_speed));
        if (got.drive_current !== want.drive_current)
            log_mismatch($sformatf("drive_current got %0d expected %0d",
                got.drive_current, want.drive_current));
        if (got.temperature !== want.temperature)
            log_mismatch($sformatf("temperature got %0d expected %0d",
                got.temperature, want.temperature));
        if (got.turn_count !== want.turn_count)
            log_mismatch($sformatf("turn_count got %0d expected %0d",
                got.turn_count, want.turn_count));
        if (got.shaft_angle !== want.shaft_angle)
            log_mismatch($sformatf("shaft_angle got %0d expected %0d",
                got.shaft_angle, want.shaft_angle));
        if (got.angle_change !== want.angle_change)
            log_mismatch($sformatf("angle_change got %0d expected %0d",
                got.angle_change, want.angle_change));
    endtask

    // Result monitor: every accepted result transaction is compared with the
    // oldest prediction. Sampling happens at the rising edge, while all block
    // inputs only move at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (unwrapped_feedback.size() == 0)
                log_mismatch("result transaction with no frame outstanding");
            else
                check_result(result, unwrapped_feedback.pop_front());
            results_checked++;
        end
    end

    // Receiver: a forced hold-off, counted down here, takes priority over the
    // random stall pattern. Exactly one assignment per falling edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                stall_hold_cycles--;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // All driving tasks below are entered at a falling edge and return at a
    // later falling edge without having assigned anything in that step, so
    // valid can stay high across back-to-back transactions.

    // Offers one frame, with random idle cycles in front, and waits for the
    // block to take it. The prediction is made at the accepting edge.
    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_valid <= 1'b0;
            @(negedge clk);
        end
        frame_valid <= 1'b1;
        frame <= f;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        unwrapped_feedback.push_back(unwrap_feedback(f));
        frames_sent++;
        @(negedge clk);
    endtask

    // Drops valid and waits until every predicted result has come back. Since
    // every frame yields a result, the block is idle at that point.
    task automatic wait_for_results;
        frame_valid <= 1'b0;
        @(negedge clk);
        while (unwrapped_feedback.size() != 0)
            @(negedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // Writes to the unimplemented address must leave the scale alone.
        if (addr == SCALE_ADDR)
            scale_q = data;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            log_mismatch($sformatf("register read at %0d got %0h expected %0h",
                addr, prdata, want));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // The scale only changes while no transaction is in flight.
    task automatic set_angle_scale(input logic [31:0] value);
        wait_for_results();
        apb_write(SCALE_ADDR, value);
        apb_read_check(SCALE_ADDR, value);
    endtask

    function automatic frame_t make_frame(input logic grp, input logic [1:0] idx,
        input logic [15:0] enc, input logic [15:0] spd, input logic [15:0] cur,
        input logic [7:0] tmp, input logic [7:0] tail);
        frame_t f;
        f.motor_group = grp;
        f.motor_index = idx;
        f.frame_payload = {enc, spd, cur, tmp, tail};
        return f;
    endfunction

    // Random frames. Most of them move a motor's encoder by a plausible step
    // from where it last was, often right at the wrap threshold, so the turn
    // counters really move; the rest carry a fully random payload.
    task automatic send_random_frames(input int count);
        frame_t f;
        int slot;
        int step;
        repeat (count)
        begin
            f.motor_group = 1'($urandom_range(1));
            f.motor_index = 2'($urandom_range(3));
            f.frame_payload = {$urandom, $urandom};
            slot = f.motor_group * MOTORS + f.motor_index;
            step = 0;
            case ($urandom_range(9))
                0, 1, 2: ;
                3, 4: step = $urandom_range(1) ? $urandom_range(4098, 4094)
                                              : -$urandom_range(4098, 4094);
                default: step = $urandom_range(12000) - 6000;
            endcase
            if (step != 0)
                f.frame_payload[63:48] = enc_state[slot] + step[15:0];
            send_frame(f);
        end
    endtask

    // One frame of the winding sequence for the chosen motor.
    task automatic wind_step(input logic [15:0] enc);
        send_frame(make_frame(WIND_GROUP, WIND_INDEX, enc, 16'($urandom),
            16'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    // Reset value of the scale, and a write to an unknown register that must
    // have no effect.
    task automatic test_register_access;
        apb_read_check(SCALE_ADDR, ANGLE_SCALE_RST);
        apb_write(UNUSED_ADDR, 32'hDEAD_BEEF);
        apb_read_check(SCALE_ADDR, ANGLE_SCALE_RST);
    endtask

    // Field extremes, the jump thresholds on both sides, the first frame after
    // reset, every motor slot but group one index zero and back-to-back frames for one motor.
    task automatic test_frame_fields;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // First frame after reset: compared against a stored zero, so 5000 is a
        // forward wrap and the counter goes to minus one.
        send_frame(make_frame(1'b0, 2'd0, 16'd5000, 16'h7FFF, 16'h8000, 8'h00, 8'hFF));
        send_frame(make_frame(1'b0, 2'd0, 16'd5000, 16'h8000, 16'h7FFF, 8'hFF, 8'h00));
        send_frame(make_frame(1'b0, 2'd0, 16'd904, 16'h0001, 16'hFFFF, 8'h80, 8'h55));
        send_frame(make_frame(1'b0, 2'd0, 16'd5001, 16'hFFFF, 16'h0001, 8'h01, 8'hAA));
        // Exactly plus and minus 4096 leave the counter alone; one more wraps.
        send_frame(make_frame(1'b0, 2'd1, 16'd4096, 16'h1234, 16'h5678, 8'h7F, 8'h00));
        send_frame(make_frame(1'b0, 2'd1, 16'd0, 16'h0000, 16'h0000, 8'h00, 8'h00));
        send_frame(make_frame(1'b0, 2'd1, 16'hFFFF, 16'hABCD, 16'hEF01, 8'h23, 8'h45));
        send_frame(make_frame(1'b0, 2'd1, 16'd61438, 16'h8001, 16'h7FFE, 8'hFE, 8'h01));
        send_frame(make_frame(1'b0, 2'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        send_frame(make_frame(1'b0, 2'd2, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
        send_frame(make_frame(1'b0, 2'd3, 16'd4097, 16'h0100, 16'hFF00, 8'h10, 8'h20));
        send_frame(make_frame(1'b1, 2'd1, 16'h8000, 16'h8000, 16'h8000, 8'h80, 8'h80));
        send_frame(make_frame(1'b1, 2'd2, 16'hFFFF, 16'h7FFF, 16'h7FFF, 8'h7F, 8'h7F));
        send_frame(make_frame(1'b1, 2'd3, 16'h1234, 16'h0000, 16'hFFFF, 8'h00, 8'hFF));
        send_frame(make_frame(1'b1, 2'd3, 16'h1234, 16'hFFFF, 16'h0000, 8'hFF, 8'h00));
        send_frame(make_frame(1'b1, 2'd3, 16'h0000, 16'h5555, 16'hAAAA, 8'h5A, 8'hA5));
    endtask

    // Scale settings: a half-count scale that exposes round half up on both
    // signs, zero, the largest and the smallest non-zero scale.
    task automatic test_scale_settings;
        set_angle_scale(32'h0000_8000);
        // That motor sits at minus one turn, so 8191 gives minus one count,
        // exactly minus one half after scaling, which rounds up to zero.
        send_frame(make_frame(1'b0, 2'd3, 16'd8191, 16'h0000, 16'h0000, 8'h00, 8'h00));
        // First visit of this motor: plus one count, plus one half, rounds to one.
        send_frame(make_frame(1'b1, 2'd0, 16'd1, 16'h0000, 16'h0000, 8'h00, 8'h00));
        set_angle_scale(32'h0000_0000);
        send_frame(make_frame(1'b0, 2'd0, 16'd3000, 16'h1111, 16'h2222, 8'h33, 8'h44));
        send_frame(make_frame(1'b1, 2'd1, 16'hC000, 16'h5555, 16'h6666, 8'h77, 8'h88));
        set_angle_scale(32'hFFFF_FFFF);
        send_frame(make_frame(1'b1, 2'd2, 16'hFFFF, 16'h9999, 16'hAAAA, 8'hBB, 8'hCC));
        send_frame(make_frame(1'b0, 2'd1, 16'd100, 16'hDDDD, 16'hEEEE, 8'hFF, 8'h00));
        set_angle_scale(32'h0000_0001);
        send_frame(make_frame(1'b0, 2'd2, 16'd7000, 16'h0F0F, 16'hF0F0, 8'h3C, 8'hC3));
        set_angle_scale(ANGLE_SCALE_RST);
    endtask

    // Bulk random traffic in three idle mixes, each under its own scale.
    task automatic test_random_traffic;
        send_idle_pct = 17;
        recv_idle_pct = 49;
        set_angle_scale($urandom);
        send_random_frames(170);
        send_idle_pct = 49;
        recv_idle_pct = 17;
        set_angle_scale(ANGLE_SCALE_RST);
        send_random_frames(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_angle_scale($urandom);
        send_random_frames(170);
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering frames, so the pipeline and skid buffer fill and the input
    // stalls. Afterwards the sender pauses until everything has drained and
    // then sends a short burst into an empty block.
    task automatic test_output_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_for_results();
        stall_hold_cycles = 300;
        send_random_frames(40);
        wait_for_results();
        send_random_frames(10);
        wait_for_results();
    endtask

    // Winds one motor backwards for two laps with the largest scale, back to
    // back, so the same entry is updated on every cycle. Each lap climbs in
    // steps just above the wrap threshold (one turn down each) and comes back
    // in steps of exactly the threshold (no change).
    task automatic test_turn_winding;
        int pos;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_angle_scale(32'hFFFF_FFFF);
        wind_step(16'd0);
        repeat (2)
        begin
            for (int k = 1; k <= 15; k++)
                wind_step(16'(4097 * k));
            pos = 4097 * 15;
            while (pos >= 4096)
            begin
                pos -= 4096;
                wind_step(16'(pos));
            end
            wind_step(16'd0);
        end
        wait_for_results();
        set_angle_scale(ANGLE_SCALE_RST);
    endtask

    // Test sequence. Reset is applied once at the start and never again.
    initial
    begin
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_access();
        test_frame_fields();
        test_scale_settings();
        test_random_traffic();
        test_output_backpressure();
        test_turn_winding();

        // Let any stray result transaction show up before the verdict.
        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        $display("Checked %0d results from %0d frames; %0d mismatches.",
            results_checked, frames_sent, mismatches);
        $display("Exercised field and scale extremes, wrap thresholds, three idle mixes, %s",
            "a long output hold-off and multi-lap winding of one motor.");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
